// ----- rtl/tbrl_pkg.sv -----
// tbrl_pkg: shared types and constants of the token bucket rate limiter
// used by every module under rtl; depends on nothing else
package tbrl_pkg;

   localparam int BAL_W   = 52;
   localparam int TIME_W  = 64;
   localparam int COUNT_W = 32;
   localparam int RATE_W  = 32;
   localparam int MICRO_W = 20;
   localparam int TOKEN_W = 32;

   localparam logic [MICRO_W-1:0] MICRO_PER_TOKEN = 20'd1000000;

   // floor(v / 1e6) = floor((v >> 6) * DIV_RECIP >> 60), exact for v < 2^52
   localparam int DIV_PRE_SHIFT = 6;
   localparam int DIV_SHIFT     = 60;
   localparam longint unsigned DIV_ODD = 64'd15625;
   localparam logic [46:0] DIV_RECIP =
      47'(((64'd1 << DIV_SHIFT) + DIV_ODD - 64'd1) / DIV_ODD);

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE  = 1'b1;

   typedef enum logic [1:0] {
      ACT_TAKE    = 2'd0,
      ACT_ADD     = 2'd1,
      ACT_RESTART = 2'd2
   } action_type;

   // classified request handed from the front to the back
   typedef struct packed {
      action_type         action;
      logic [BAL_W-1:0]   cost;
      logic [BAL_W-1:0]   accrual;
   } work_type;

endpackage

// ----- rtl/tbrl_front.sv -----
// tbrl_front: accepts requests, tracks the time mark and computes the
// accrual (elapsed time times rate, saturated) and the cost; uses tbrl_pkg
module tbrl_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tbrl_pkg::RATE_W-1:0]     rate,
   input  logic [tbrl_pkg::BAL_W-1:0]      cap,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [tbrl_pkg::COUNT_W-1:0]    req_count,
   input  logic [tbrl_pkg::TIME_W-1:0]     req_now_time,
   output logic                            push,
   output tbrl_pkg::work_type              push_data,
   input  logic                            full
);

   logic                               front_en;
   logic                               accept;
   tbrl_pkg::action_type               req_act;
   logic [tbrl_pkg::TIME_W-1:0]        time_diff;
   logic                               accrue;

   logic [tbrl_pkg::TIME_W-1:0]        last_time_ff, last_time_in;
   logic                               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   tbrl_pkg::action_type               s1_action_ff, s2_action_ff, s3_action_ff, s4_action_ff;
   logic [tbrl_pkg::BAL_W-1:0]         s1_cost_ff, s2_cost_ff, s3_cost_ff, s4_cost_ff;
   logic [tbrl_pkg::BAL_W-1:0]         s1_cost_in;
   logic [tbrl_pkg::BAL_W-1:0]         s1_delta_ff, s1_delta_in;
   logic                               s1_over_ff, s2_over_ff, s3_over_ff;
   logic                               s1_over_in;
   logic [57:0]                        s2_pp_lo_ff, s2_pp_lo_in;
   logic [57:0]                        s2_pp_hi_ff, s2_pp_hi_in;
   logic [83:0]                        s3_prod_ff, s3_prod_in;
   logic                               s4_too_big;
   logic [tbrl_pkg::BAL_W-1:0]         s4_accrual_ff, s4_accrual_in;

   assign front_en  = !(s4_valid_ff && full);
   assign req_stall = !front_en;
   assign accept    = req_valid && front_en;
   assign req_act   = tbrl_pkg::action_type'(req_action);

   assign time_diff = req_now_time - last_time_ff;
   assign accrue    = (req_act == tbrl_pkg::ACT_TAKE) && (rate != '0)
                      && (req_now_time > last_time_ff);

   always_comb begin
      last_time_in = last_time_ff;
      if (accept && (req_act == tbrl_pkg::ACT_TAKE || req_act == tbrl_pkg::ACT_RESTART)) begin
         last_time_in = req_now_time;
      end
   end

   assign s1_cost_in  = 52'({20'd0, req_count} * {32'd0, tbrl_pkg::MICRO_PER_TOKEN});
   assign s1_delta_in = accrue ? time_diff[51:0] : '0;
   // a gap of 2^52 us or more always overruns any cap
   assign s1_over_in  = accrue && (|time_diff[63:52]);

   assign s2_pp_lo_in = {32'd0, s1_delta_ff[25:0]} * {26'd0, rate};
   assign s2_pp_hi_in = {32'd0, s1_delta_ff[51:26]} * {26'd0, rate};

   assign s3_prod_in  = {26'd0, s2_pp_lo_ff} + {s2_pp_hi_ff, 26'd0};

   assign s4_too_big    = s3_over_ff || (|s3_prod_ff[83:52]) || (s3_prod_ff[51:0] > cap);
   assign s4_accrual_in = s4_too_big ? cap : s3_prod_ff[51:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
      end else begin
         last_time_ff <= last_time_in;
         if (front_en) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s1_action_ff  <= req_act;
         s1_cost_ff    <= s1_cost_in;
         s1_delta_ff   <= s1_delta_in;
         s1_over_ff    <= s1_over_in;

         s2_action_ff  <= s1_action_ff;
         s2_cost_ff    <= s1_cost_ff;
         s2_over_ff    <= s1_over_ff;
         s2_pp_lo_ff   <= s2_pp_lo_in;
         s2_pp_hi_ff   <= s2_pp_hi_in;

         s3_action_ff  <= s2_action_ff;
         s3_cost_ff    <= s2_cost_ff;
         s3_over_ff    <= s2_over_ff;
         s3_prod_ff    <= s3_prod_in;

         s4_action_ff  <= s3_action_ff;
         s4_cost_ff    <= s3_cost_ff;
         s4_accrual_ff <= s4_accrual_in;
      end
   end

   assign push              = s4_valid_ff && !full;
   assign push_data.action  = s4_action_ff;
   assign push_data.cost    = s4_cost_ff;
   assign push_data.accrual = s4_accrual_ff;

endmodule

// ----- rtl/tbrl_queue.sv -----
// tbrl_queue: short first-in first-out queue of classified requests
// between the front and the back; uses tbrl_pkg
module tbrl_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tbrl_pkg::work_type   push_data,
   input  logic                 pop,
   output tbrl_pkg::work_type   pop_data,
   output logic                 empty,
   output logic                 full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tbrl_pkg::work_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/tbrl_back.sv -----
// tbrl_back: applies one request per cycle while en is high to the running
// balance: refill and cap, grant check and debit, add, restart; uses tbrl_pkg
module tbrl_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tbrl_pkg::BAL_W-1:0]    cap,
   input  logic                          en,
   input  logic                          q_empty,
   input  tbrl_pkg::work_type            q_data,
   output logic                          pop,
   output logic                          out_valid,
   output logic                          out_granted,
   output logic [tbrl_pkg::BAL_W-1:0]    out_value
);

   logic [tbrl_pkg::BAL_W-1:0]   balance_ff, balance_in;
   logic                         valid_ff;
   logic                         granted_ff, granted_in;
   logic [tbrl_pkg::BAL_W-1:0]   value_ff, value_in;

   logic [tbrl_pkg::BAL_W-1:0]   addend;
   logic [tbrl_pkg::BAL_W:0]     sum;
   logic [tbrl_pkg::BAL_W-1:0]   capped;
   logic [tbrl_pkg::BAL_W-1:0]   next_balance;

   assign pop = en && !q_empty;

   // take refills by the accrual, add puts in the cost; both share the adder
   assign addend = (q_data.action == tbrl_pkg::ACT_ADD) ? q_data.cost : q_data.accrual;
   assign sum    = {1'b0, balance_ff} + {1'b0, addend};
   assign capped = (sum > {1'b0, cap}) ? cap : sum[tbrl_pkg::BAL_W-1:0];

   always_comb begin
      granted_in   = 1'b1;
      value_in     = capped;
      next_balance = capped;
      case (q_data.action)
         tbrl_pkg::ACT_TAKE: begin
            if (capped >= q_data.cost) begin
               next_balance = capped - q_data.cost;
            end else begin
               granted_in = 1'b0;
            end
         end
         tbrl_pkg::ACT_ADD: begin
            next_balance = capped;
         end
         tbrl_pkg::ACT_RESTART: begin
            next_balance = cap;
            value_in     = cap;
         end
         default: begin
            // unused code: report stored balance, change nothing
            granted_in   = 1'b0;
            value_in     = balance_ff;
            next_balance = balance_ff;
         end
      endcase
   end

   assign balance_in = pop ? next_balance : balance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         balance_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         balance_ff <= balance_in;
         if (en) begin
            valid_ff <= !q_empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         granted_ff <= granted_in;
         value_ff   <= value_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_granted = granted_ff;
   assign out_value   = value_ff;

`ifndef NO_ASSERTIONS
   a_balance_capped: assert property (@(posedge clock) disable iff (reset)
      (pop && (q_data.action == tbrl_pkg::ACT_TAKE || q_data.action == tbrl_pkg::ACT_ADD
               || q_data.action == tbrl_pkg::ACT_RESTART))
      |=> balance_ff <= $past(cap))
      else $error("balance above cap after update");
`endif

endmodule

// ----- rtl/tbrl_div.sv -----
// tbrl_div: pipelined divide of micro-tokens by one million through a
// reciprocal multiply, ending in the result register; uses tbrl_pkg
module tbrl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          in_granted,
   input  logic [tbrl_pkg::BAL_W-1:0]    in_value,
   output logic                          en,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_granted,
   output logic [tbrl_pkg::TOKEN_W-1:0]  rsp_tokens_available
);

   localparam logic [23:0] RECIP_LO = tbrl_pkg::DIV_RECIP[23:0];
   localparam logic [22:0] RECIP_HI = tbrl_pkg::DIV_RECIP[46:24];

   logic [45:0]   y;
   logic [22:0]   y_lo, y_hi;

   logic          d1_valid_ff, d2_valid_ff, d3_valid_ff;
   logic          d1_granted_ff, d2_granted_ff, d3_granted_ff;
   logic [46:0]   d1_ll_ff, d1_ll_in;
   logic [45:0]   d1_lh_ff, d1_lh_in;
   logic [46:0]   d1_hl_ff, d1_hl_in;
   logic [45:0]   d1_hh_ff, d1_hh_in;
   logic [70:0]   d2_sum_a_ff, d2_sum_a_in;
   logic [70:0]   d2_sum_b_ff, d2_sum_b_in;
   logic [93:0]   total;
   logic [tbrl_pkg::TOKEN_W-1:0] d3_tokens_ff, d3_tokens_in;

   assign en = !(d3_valid_ff && rsp_stall);

   // the low six bits of one million are zeros, so divide by 15625 after a shift
   assign y    = in_value[tbrl_pkg::BAL_W-1:tbrl_pkg::DIV_PRE_SHIFT];
   assign y_lo = y[22:0];
   assign y_hi = y[45:23];

   assign d1_ll_in = {24'd0, y_lo} * {23'd0, RECIP_LO};
   assign d1_lh_in = {23'd0, y_lo} * {23'd0, RECIP_HI};
   assign d1_hl_in = {24'd0, y_hi} * {23'd0, RECIP_LO};
   assign d1_hh_in = {23'd0, y_hi} * {23'd0, RECIP_HI};

   assign d2_sum_a_in = {24'd0, d1_ll_ff} + {1'b0, d1_lh_ff, 24'd0};
   assign d2_sum_b_in = {24'd0, d1_hl_ff} + {1'b0, d1_hh_ff, 24'd0};

   assign total        = {23'd0, d2_sum_a_ff} + {d2_sum_b_ff, 23'd0};
   assign d3_tokens_in = total[tbrl_pkg::DIV_SHIFT + tbrl_pkg::TOKEN_W - 1:tbrl_pkg::DIV_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         d3_valid_ff <= 1'b0;
      end else if (en) begin
         d1_valid_ff <= in_valid;
         d2_valid_ff <= d1_valid_ff;
         d3_valid_ff <= d2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_granted_ff <= in_granted;
         d1_ll_ff      <= d1_ll_in;
         d1_lh_ff      <= d1_lh_in;
         d1_hl_ff      <= d1_hl_in;
         d1_hh_ff      <= d1_hh_in;

         d2_granted_ff <= d1_granted_ff;
         d2_sum_a_ff   <= d2_sum_a_in;
         d2_sum_b_ff   <= d2_sum_b_in;

         d3_granted_ff <= d2_granted_ff;
         d3_tokens_ff  <= d3_tokens_in;
      end
   end

   assign rsp_valid            = d3_valid_ff;
   assign rsp_granted          = d3_granted_ff;
   assign rsp_tokens_available = d3_tokens_ff;

`ifndef NO_ASSERTIONS
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");
`endif

endmodule

// ----- rtl/token_bucket_rate_limiter_top.sv -----
// token_bucket_rate_limiter_top: configuration registers and the
// front, queue, back and divide pipeline; uses tbrl_pkg and all rtl modules

// Token bucket rate limiter. The balance is kept in micro-tokens and refilled
// from the microsecond timestamp of each take; burst_tokens (index 0) caps the
// bucket and refill_rate (index 1) is tokens per second. Every request gives one
// result beat. A new request is taken every cycle while req_stall is low; each
// request passes the four-stage front (time delta, split multiply of delta by
// rate, sum, saturate), the registered balance update in the back, and the
// three-stage reciprocal multiply that turns micro-tokens into whole tokens. A
// queue of QUEUE_DEPTH requests sits between front and back so that a stalled
// result side does not stall the request side until the queue fills.
// Write the registers only with no request in flight.
module token_bucket_rate_limiter_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic [tbrl_pkg::COUNT_W-1:0]          req_count,
   input  logic [tbrl_pkg::TIME_W-1:0]           req_now_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_granted,
   output logic [tbrl_pkg::TOKEN_W-1:0]          rsp_tokens_available,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tbrl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                           csr_wdata
);

   logic [tbrl_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic [tbrl_pkg::BAL_W-1:0]    cap_ff, cap_in;
   logic                          csr_write;

   logic                          push, pop, q_empty, q_full;
   tbrl_pkg::work_type            push_data, pop_data;
   logic                          back_en;
   logic                          b_valid, b_granted;
   logic [tbrl_pkg::BAL_W-1:0]    b_value;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // burst is held as its cap in micro-tokens
   always_comb begin
      rate_in = rate_ff;
      cap_in  = cap_ff;
      if (csr_write) begin
         case (csr_index)
            tbrl_pkg::CSR_BURST: cap_in  = 52'({20'd0, csr_wdata} *
                                               {32'd0, tbrl_pkg::MICRO_PER_TOKEN});
            tbrl_pkg::CSR_RATE:  rate_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
         cap_ff  <= '0;
      end else begin
         rate_ff <= rate_in;
         cap_ff  <= cap_in;
      end
   end

   tbrl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .rate         (rate_ff),
      .cap          (cap_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_count    (req_count),
      .req_now_time (req_now_time),
      .push         (push),
      .push_data    (push_data),
      .full         (q_full)
   );

   tbrl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   tbrl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cap         (cap_ff),
      .en          (back_en),
      .q_empty     (q_empty),
      .q_data      (pop_data),
      .pop         (pop),
      .out_valid   (b_valid),
      .out_granted (b_granted),
      .out_value   (b_value)
   );

   tbrl_div u_div (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (b_valid),
      .in_granted           (b_granted),
      .in_value             (b_value),
      .en                   (back_en),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_granted          (rsp_granted),
      .rsp_tokens_available (rsp_tokens_available)
   );

endmodule

// ----- tb/token_bucket_checker.sv -----
// token_bucket_checker: watches the request, result and register channels of
// the rate limiter, predicts each result and compares it; uses tbrl_pkg
module token_bucket_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [tbrl_pkg::COUNT_W-1:0]      req_count,
   input  logic [tbrl_pkg::TIME_W-1:0]       req_now_time,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_granted,
   input  logic [tbrl_pkg::TOKEN_W-1:0]      rsp_tokens_available,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [tbrl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_wdata,
   output int                                n_fail,
   output int                                n_pending,
   output int                                n_checked,
   output int                                n_granted,
   output int                                n_held
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] TOKEN_MICRO = 64'(tbrl_pkg::MICRO_PER_TOKEN);

   typedef struct packed {
      logic                         granted;
      logic [tbrl_pkg::TOKEN_W-1:0] tokens;
   } bucket_result_type;

   logic [31:0]                 cfg_burst;
   logic [31:0]                 cfg_rate;
   logic [tbrl_pkg::BAL_W-1:0]  bucket_micro;
   logic [tbrl_pkg::TIME_W-1:0] mark_time;

   bucket_result_type pending_results[$];
   int fails, checked, granted_seen, held;

   function automatic bucket_result_type bucket_step(
         input logic [1:0]                   act,
         input logic [tbrl_pkg::COUNT_W-1:0] cnt,
         input logic [tbrl_pkg::TIME_W-1:0]  now_t);
      logic [63:0] cap, acc, delta, avail, cost, next_bal;
      bucket_result_type res;
      cap = 64'(cfg_burst) * TOKEN_MICRO;
      res.granted = 1'b1;
      case (act)
         tbrl_pkg::ACT_TAKE: begin
            acc = '0;
            if (cfg_rate != 0 && now_t > mark_time) begin
               delta = now_t - mark_time;
               // elapsed times rate saturates to the cap
               if (delta > cap / 64'(cfg_rate))
                  acc = cap;
               else
                  acc = delta * 64'(cfg_rate);
            end
            avail = 64'(bucket_micro) + acc;
            if (avail > cap)
               avail = cap;
            cost = 64'(cnt) * TOKEN_MICRO;
            res.tokens = tbrl_pkg::TOKEN_W'(avail / TOKEN_MICRO);
            // a refused take still keeps the refilled balance
            if (avail >= cost) begin
               bucket_micro = tbrl_pkg::BAL_W'(avail - cost);
            end else begin
               bucket_micro = tbrl_pkg::BAL_W'(avail);
               res.granted = 1'b0;
            end
            mark_time = now_t;
         end
         tbrl_pkg::ACT_ADD: begin
            next_bal = 64'(bucket_micro) + 64'(cnt) * TOKEN_MICRO;
            if (next_bal > cap)
               next_bal = cap;
            bucket_micro = tbrl_pkg::BAL_W'(next_bal);
            res.tokens = tbrl_pkg::TOKEN_W'(64'(bucket_micro) / TOKEN_MICRO);
         end
         tbrl_pkg::ACT_RESTART: begin
            bucket_micro = tbrl_pkg::BAL_W'(cap);
            mark_time = now_t;
            res.tokens = cfg_burst;
         end
         default: begin
            // unused code leaves the bucket alone and reports the raw balance
            res.granted = 1'b0;
            res.tokens = tbrl_pkg::TOKEN_W'(64'(bucket_micro) / TOKEN_MICRO);
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      bucket_result_type got, want;
      if (reset) begin
         cfg_burst = '0;
         cfg_rate = '0;
         bucket_micro = '0;
         mark_time = '0;
         pending_results.delete();
         fails = 0;
         checked = 0;
         granted_seen = 0;
         held = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tbrl_pkg::CSR_BURST: cfg_burst = csr_wdata;
               tbrl_pkg::CSR_RATE:  cfg_rate = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_granted, rsp_tokens_available};
            if (pending_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: result beat with nothing pending: granted %0d tokens %0d",
                           $realtime, got.granted, got.tokens);
            end else begin
               want = pending_results.pop_front();
               if (want.granted !== got.granted || want.tokens !== got.tokens) begin
                  fails++;
                  if (fails <= 10)
                     $display({"%0t: result %0d wrong: granted exp %0d got %0d, ",
                               "tokens exp %0d got %0d"},
                              $realtime, checked, want.granted, got.granted,
                              want.tokens, got.tokens);
               end
               checked++;
               if (got.granted === 1'b1)
                  granted_seen++;
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(bucket_step(req_action, req_count, req_now_time));
         if (req_valid && req_stall)
            held++;
      end
      n_fail <= fails;
      n_pending <= pending_results.size();
      n_checked <= checked;
      n_granted <= granted_seen;
      n_held <= held;
   end

endmodule

// ----- tb/tb.sv -----
// tb: clock, reset, request and register stimulus for the token bucket rate
// limiter; uses tbrl_pkg, token_bucket_rate_limiter_top and token_bucket_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int SEG_ITEMS = 200;
   localparam int SEG_COUNT = 8;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [1:0]                       req_action;
   logic [tbrl_pkg::COUNT_W-1:0]     req_count;
   logic [tbrl_pkg::TIME_W-1:0]      req_now_time;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_granted;
   logic [tbrl_pkg::TOKEN_W-1:0]     rsp_tokens_available;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [tbrl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0]                      csr_wdata;

   int n_fail, n_pending, n_checked, n_granted, n_held;

   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_request;
   int          hold_left;
   int          n_settings;
   logic [63:0] stamp_us;

   token_bucket_rate_limiter_top u_dut (.*);

   token_bucket_checker u_checker (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end

   // result side: random stall, or a long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [1:0] act,
                            input logic [tbrl_pkg::COUNT_W-1:0] cnt,
                            input logic [tbrl_pkg::TIME_W-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_count <= cnt;
      req_now_time <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (n_pending != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic program_bucket(input logic [31:0] burst, input logic [31:0] rate);
      csr_valid <= 1'b1;
      csr_index <= tbrl_pkg::CSR_BURST;
      csr_wdata <= burst;
      do @(posedge clock); while (!csr_ready);
      csr_index <= tbrl_pkg::CSR_RATE;
      csr_wdata <= rate;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic random_item();
      int r;
      logic [1:0] act;
      logic [tbrl_pkg::COUNT_W-1:0] cnt;
      r = $urandom_range(99);
      if (r < 70)
         act = tbrl_pkg::ACT_TAKE;
      else if (r < 82)
         act = tbrl_pkg::ACT_ADD;
      else if (r < 96)
         act = tbrl_pkg::ACT_RESTART;
      else
         act = ACT_UNUSED;
      r = $urandom_range(99);
      if (r < 60)
         cnt = $urandom_range(0, 8);
      else if (r < 80)
         cnt = $urandom_range(0, 200);
      else if (r < 93)
         cnt = $urandom();
      else
         cnt = ($urandom_range(1) != 0) ? '1 : '0;
      // mostly a clock that creeps forward, sometimes stalls, jumps or goes back
      r = $urandom_range(99);
      if (r < 55)
         stamp_us += $urandom_range(0, 20);
      else if (r < 75)
         stamp_us += $urandom_range(0, 5000);
      else if (r < 84)
         stamp_us += $urandom();
      else if (r < 90)
         stamp_us = stamp_us;
      else if (r < 96)
         stamp_us -= $urandom_range(0, 50);
      else
         stamp_us = {$urandom(), $urandom()};
      send_item(act, cnt, stamp_us);
   endtask

   initial begin
      int seg, k;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= tbrl_pkg::ACT_TAKE;
      req_count <= '0;
      req_now_time <= '0;
      csr_valid <= 1'b0;
      csr_index <= tbrl_pkg::CSR_BURST;
      csr_wdata <= '0;
      hold_request = 1'b0;
      n_settings = 0;
      stamp_us = '0;
      send_idle_pct = 8;
      recv_stall_pct = 80;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one token per microsecond, ten tokens deep
      program_bucket(32'd10, 32'd1000000);
      send_item(tbrl_pkg::ACT_TAKE, 32'd0, 64'd0);
      send_item(tbrl_pkg::ACT_TAKE, 32'd1, 64'd0);
      send_item(tbrl_pkg::ACT_TAKE, 32'd3, 64'd5);
      send_item(tbrl_pkg::ACT_TAKE, 32'd0, 64'd5);
      send_item(tbrl_pkg::ACT_TAKE, 32'd1, 64'd3);
      send_item(tbrl_pkg::ACT_ADD, 32'd4, 64'd0);
      send_item(tbrl_pkg::ACT_ADD, '1, 64'd0);
      send_item(tbrl_pkg::ACT_RESTART, 32'd0, 64'd100);
      send_item(tbrl_pkg::ACT_TAKE, '1, 64'd200);
      send_item(tbrl_pkg::ACT_TAKE, 32'd10, 64'd200);
      send_item(ACT_UNUSED, '1, '1);
      send_item(tbrl_pkg::ACT_TAKE, 32'd0, '1);
      wait_for_quiet();

      program_bucket('1, '1);
      send_item(tbrl_pkg::ACT_RESTART, '1, 64'd0);
      send_item(tbrl_pkg::ACT_TAKE, '1, 64'd1);
      send_item(tbrl_pkg::ACT_TAKE, 32'd1, '1);
      send_item(tbrl_pkg::ACT_TAKE, 32'd0, 64'd2);
      wait_for_quiet();

      // burst lowered under a full balance, no time refill
      program_bucket(32'd3, 32'd0);
      send_item(tbrl_pkg::ACT_TAKE, 32'd0, 64'd10);
      send_item(tbrl_pkg::ACT_TAKE, 32'd1, 64'd500);
      send_item(tbrl_pkg::ACT_ADD, 32'd0, 64'd0);
      wait_for_quiet();
      program_bucket('1, 32'd0);
      send_item(tbrl_pkg::ACT_RESTART, 32'd0, 64'd7);
      wait_for_quiet();
      program_bucket(32'd3, 32'd0);
      send_item(tbrl_pkg::ACT_ADD, 32'd0, 64'd0);
      wait_for_quiet();

      stamp_us = 64'd1000;
      for (seg = 0; seg < SEG_COUNT; seg++) begin
         if (seg < 3) begin
            send_idle_pct = 8;
            recv_stall_pct = 80;
         end else if (seg < 6) begin
            send_idle_pct = 80;
            recv_stall_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         case (seg)
            0: program_bucket(32'd10, 32'd250000);
            1: program_bucket(32'd0, 32'd0);
            2: program_bucket(32'd100, 32'd3);
            3: program_bucket('1, '1);
            4: program_bucket(32'd5, 32'd1000000);
            5: program_bucket(32'd1, '1);
            6: program_bucket('1, 32'd1);
            default: program_bucket($urandom_range(1, 64), $urandom());
         endcase
         for (k = 0; k < SEG_ITEMS; k++) begin
            // block the result side long enough to back up the input
            if (seg == 6 && k == 40)
               hold_request = 1'b1;
            random_item();
         end
         wait_for_quiet();
      end

      repeat (20) @(posedge clock);
      $display("checked %0d results (%0d granted) across %0d bucket settings",
               n_checked, n_granted, n_settings);
      $display("request side was held back for %0d cycles", n_held);
      if (n_fail == 0 && n_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tbrl_pkg.sv
rtl/tbrl_front.sv
rtl/tbrl_queue.sv
rtl/tbrl_back.sv
rtl/tbrl_div.sv
rtl/token_bucket_rate_limiter_top.sv
tb/token_bucket_checker.sv
tb/tb.sv
